/* design/bcp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_pkg
// Shared types and constants for the midpoint circle point generator.
// ----------------------------------------------------------------------------
package bcp_pkg;

  localparam int CoordW  = 10;  // centre coordinate width
  localparam int RadW    = 5;   // radius field width
  localparam int PtW     = 12;  // signed point width
  localparam int OfsW    = 8;   // signed x/y offset width, covers the result cap
  localparam int DecW    = 12;  // signed decision value width
  localparam int CntW    = 6;   // result counter width
  localparam int ResultCap       = 64;
  localparam int MaxRadiusDefault = 31;

  typedef struct packed {
    logic load;  // capture a new request and reset the walk
    logic step;  // register one result and advance the walk
  } bcp_cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being taken this cycle
    logic last;      // current iteration is the final one
  } bcp_sts_t;

endpackage

/* design/bcp_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_req_if
// Circle request channel: centre and radius with valid/ready.
// ----------------------------------------------------------------------------
interface bcp_req_if;
  logic       valid;
  logic       ready;
  logic [9:0] center_x;
  logic [9:0] center_y;
  logic [4:0] radius;

  modport source (output valid, output center_x, output center_y, output radius,
                  input ready);
  modport sink   (input valid, input center_x, input center_y, input radius,
                  output ready);
endinterface

/* design/bcp_pt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_pt_if
// Point channel: four mirrored coordinates and an end-of-circle flag.
// ----------------------------------------------------------------------------
interface bcp_pt_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] right_x;
  logic signed [11:0] left_x;
  logic signed [11:0] lower_y;
  logic signed [11:0] upper_y;
  logic               last_point;

  modport source (output valid, output right_x, output left_x, output lower_y,
                  output upper_y, output last_point, input ready);
  modport sink   (input valid, input right_x, input left_x, input lower_y,
                  input upper_y, input last_point, output ready);
endinterface

/* design/bresenham_circle_points_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_circle_points_core
// Midpoint circle generator: one request in, one result per iteration out.
// ----------------------------------------------------------------------------
// Usage:
//   req carries a centre and a radius; a transfer happens when valid and
//   ready are both high. ready is high only while the walk is idle.
//   pt carries the four mirrored coordinates of one iteration; last_point
//   marks the final result of a circle. Axis points are repeated as-is.
//   Radii above MAX_RADIUS are clamped to it; at most 64 results per circle.
// Timing:
//   The request is taken while idle, then one result per cycle while the
//   receiver keeps ready high; each result is presented from the output
//   register in the cycle after the step that computes it. Zero radius
//   gives one result.
//   A stall on pt holds the output register and freezes the walk; a new
//   request can be taken while the last result of the previous one waits.
// Reset:
//   rst is synchronous; it returns the controller to idle and empties the
//   output register.
// ----------------------------------------------------------------------------
module bresenham_circle_points_core #(
  parameter int MAX_RADIUS = bcp_pkg::MaxRadiusDefault
) (
  input  logic     clk,
  input  logic     rst,
  bcp_req_if.sink  req,
  bcp_pt_if.source pt
);
  import bcp_pkg::*;

  bcp_cmd_t cmd;
  bcp_sts_t sts;

  bcp_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bcp_dp #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .center_x   (req.center_x),
    .center_y   (req.center_y),
    .radius     (req.radius),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (pt.valid),
    .out_ready  (pt.ready),
    .right_x    (pt.right_x),
    .left_x     (pt.left_x),
    .lower_y    (pt.lower_y),
    .upper_y    (pt.upper_y),
    .last_point (pt.last_point)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken but controller did not go busy");

  a_load_step_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.step)
    else $error("load and step in the same cycle");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.step && sts.last |=> req.ready)
    else $error("controller not idle after final iteration");

  a_step_fills_out: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> pt.valid)
    else $error("stepped result not presented");

endmodule

/* design/bcp_ctl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_ctl
// Controller: takes a request in idle, then steps the walk once per free
// output slot until the final iteration.
// ----------------------------------------------------------------------------
module bcp_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bcp_pkg::bcp_sts_t sts,
  output bcp_pkg::bcp_cmd_t cmd
);
  import bcp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    req_ready  = (state == ST_IDLE);
    cmd.load   = (state == ST_IDLE) && req_valid;
    cmd.step   = (state == ST_RUN) && sts.out_free;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (sts.out_free && sts.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/bcp_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcp_dp
// Datapath: walk registers, decision update, mirrored point adders and the
// output register.
// ----------------------------------------------------------------------------
module bcp_dp #(
  parameter int MAX_RADIUS = bcp_pkg::MaxRadiusDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bcp_pkg::CoordW-1:0]    center_x,
  input  logic [bcp_pkg::CoordW-1:0]    center_y,
  input  logic [bcp_pkg::RadW-1:0]      radius,
  input  bcp_pkg::bcp_cmd_t             cmd,
  output bcp_pkg::bcp_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [bcp_pkg::PtW-1:0] right_x,
  output logic signed [bcp_pkg::PtW-1:0] left_x,
  output logic signed [bcp_pkg::PtW-1:0] lower_y,
  output logic signed [bcp_pkg::PtW-1:0] upper_y,
  output logic                          last_point
);
  import bcp_pkg::*;

  localparam logic [OfsW-1:0] MaxR = OfsW'(MAX_RADIUS);

  logic        [CoordW-1:0] cx;
  logic        [CoordW-1:0] cy;
  logic signed [OfsW-1:0]   x;
  logic signed [OfsW-1:0]   y;
  logic signed [DecW-1:0]   d;
  logic        [CntW-1:0]   cnt;

  logic        [OfsW-1:0]   rad_ext;
  logic        [OfsW-1:0]   rad_sat;
  logic signed [OfsW-1:0]   x_next;
  logic signed [OfsW-1:0]   y_next;
  logic signed [DecW-1:0]   d_next;
  logic signed [DecW-1:0]   x_ext;
  logic signed [DecW-1:0]   y_ext;
  logic signed [DecW-1:0]   dy_sum;
  logic signed [DecW:0]     err;
  logic                     d_neg;
  logic                     d_pos;
  logic                     err_le0;
  logic                     err_gt0;
  logic signed [PtW-1:0]    cx_pt;
  logic signed [PtW-1:0]    cy_pt;
  logic signed [PtW-1:0]    x_pt;
  logic signed [PtW-1:0]    y_pt;

  always_comb begin
    rad_ext = {{(OfsW-RadW){1'b0}}, radius};
    rad_sat = (rad_ext > MaxR) ? MaxR : rad_ext;

    x_ext  = {{(DecW-OfsW){x[OfsW-1]}}, x};
    y_ext  = {{(DecW-OfsW){y[OfsW-1]}}, y};
    dy_sum = d + y_ext;
    err    = {dy_sum, 1'b0} - (DecW+1)'(1);

    d_neg   = d[DecW-1];
    d_pos   = !d[DecW-1] && (d != '0);
    err_le0 = err[DecW] || (err == '0);
    err_gt0 = !err_le0;

    // pick diagonal unless the error favors a pure horizontal or vertical move
    if (d_neg && err_le0) begin
      x_next = x + OfsW'(1);
      y_next = y;
      d_next = d + {x_ext[DecW-2:0], 1'b0} + DecW'(3);
    end else if (d_pos && err_gt0) begin
      x_next = x;
      y_next = y - OfsW'(1);
      d_next = d - {y_ext[DecW-2:0], 1'b0} + DecW'(1);
    end else begin
      x_next = x + OfsW'(1);
      y_next = y - OfsW'(1);
      d_next = d + ((x_ext - y_ext) <<< 1) + DecW'(4);
    end

    sts.last     = y_next[OfsW-1] || (cnt == CntW'(ResultCap - 1));
    sts.out_free = !out_valid || out_ready;

    cx_pt = {{(PtW-CoordW){1'b0}}, cx};
    cy_pt = {{(PtW-CoordW){1'b0}}, cy};
    x_pt  = {{(PtW-OfsW){x[OfsW-1]}}, x};
    y_pt  = {{(PtW-OfsW){y[OfsW-1]}}, y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx  <= '0;
      cy  <= '0;
      x   <= '0;
      y   <= '0;
      d   <= '0;
      cnt <= '0;
    end else if (cmd.load) begin
      cx  <= center_x;
      cy  <= center_y;
      x   <= '0;
      y   <= rad_sat;
      d   <= DecW'(1) - {{(DecW-OfsW-1){1'b0}}, rad_sat, 1'b0};
      cnt <= '0;
    end else if (cmd.step) begin
      x   <= x_next;
      y   <= y_next;
      d   <= d_next;
      cnt <= cnt + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      right_x    <= cx_pt + x_pt;
      left_x     <= cx_pt - x_pt;
      lower_y    <= cy_pt + y_pt;
      upper_y    <= cy_pt - y_pt;
      last_point <= sts.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the midpoint circle point generator: directed
// circles at the coordinate and radius extremes, then random circles, with
// every emitted point compared against its hand-written point or an in-bench model of the error walk.
// ----------------------------------------------------------------------------
module testbench;
  import bcp_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 8;
  localparam int MaxRadius   = MaxRadiusDefault;
  localparam int RandCircles = 164;
  localparam int MaxGap      = 16;
  localparam int LongHold    = 400;
  localparam int DrainCycles = 80;
  localparam int WatchdogNs  = 10_000_000;
  localparam int DirRows     = 16;

  typedef logic signed [PtW-1:0] coord_t;

  typedef struct packed {
    coord_t right_x;
    coord_t left_x;
    coord_t lower_y;
    coord_t upper_y;
    logic   last_point;
  } point_t;

  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [RadW-1:0]   r;
    logic              typed;  // pt holds the hand-written single point
    point_t            pt;
  } circle_row_t;

  // Zero-radius rows carry their only point; the rest go through the model.
  circle_row_t dir_rows [DirRows] = '{
    '{10'd0,    10'd0,    5'd0,  1'b1, '{12'sd0,    12'sd0,    12'sd0,    12'sd0,    1'b1}},
    '{10'd1023, 10'd1023, 5'd0,  1'b1, '{12'sd1023, 12'sd1023, 12'sd1023, 12'sd1023, 1'b1}},
    '{10'd1023, 10'd0,    5'd0,  1'b1, '{12'sd1023, 12'sd1023, 12'sd0,    12'sd0,    1'b1}},
    '{10'd0,    10'd0,    5'd1,  1'b0, '0},
    '{10'd0,    10'd0,    5'd31, 1'b0, '0},
    '{10'd1023, 10'd1023, 5'd31, 1'b0, '0},
    '{10'd512,  10'd512,  5'd2,  1'b0, '0},
    '{10'd341,  10'd682,  5'd3,  1'b0, '0},
    '{10'd682,  10'd341,  5'd16, 1'b0, '0},
    '{10'd1,    10'd1022, 5'd30, 1'b0, '0},
    '{10'd100,  10'd900,  5'd5,  1'b0, '0},
    '{10'd1023, 10'd0,    5'd31, 1'b0, '0},
    '{10'd0,    10'd1023, 5'd31, 1'b0, '0},
    '{10'd300,  10'd300,  5'd7,  1'b0, '0},
    '{10'd31,   10'd31,   5'd31, 1'b0, '0},
    '{10'd600,  10'd400,  5'd1,  1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  bcp_req_if req ();
  bcp_pt_if  pt ();

  bresenham_circle_points_core #(
    .MAX_RADIUS(MaxRadius)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .pt (pt)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Walk state of the model
  logic [CoordW-1:0] held_cx;
  logic [CoordW-1:0] held_cy;
  int                walk_x;
  int                walk_y;
  int                walk_d;

  point_t pending_points[$];
  point_t head_pt;

  int err_count     = 0;
  int circles_sent  = 0;
  int points_seen   = 0;
  int biggest_walk  = 0;
  int zero_circles  = 0;
  int full_circles  = 0;
  bit long_hold_done = 1'b0;

  // Run the midpoint walk for one request and queue every point it yields.
  function automatic void walk_circle(input logic [CoordW-1:0] cx,
                                      input logic [CoordW-1:0] cy,
                                      input logic [RadW-1:0] r);
    int     rad;
    int     err;
    int     n;
    bit     done;
    point_t p;
    rad = r;
    if (rad > MaxRadius) rad = MaxRadius;
    held_cx = cx;
    held_cy = cy;
    walk_x  = 0;
    walk_y  = rad;
    walk_d  = 1 - 2 * rad;
    n       = 0;
    done    = 1'b0;
    while (!done) begin
      p.right_x = coord_t'(int'(held_cx) + walk_x);
      p.left_x  = coord_t'(int'(held_cx) - walk_x);
      p.lower_y = coord_t'(int'(held_cy) + walk_y);
      p.upper_y = coord_t'(int'(held_cy) - walk_y);
      err = 2 * (walk_d + walk_y) - 1;
      if (walk_d < 0 && err <= 0) begin
        walk_x += 1;
        walk_d += 2 * walk_x + 1;
      end else if (walk_d > 0 && err > 0) begin
        walk_y -= 1;
        walk_d -= 2 * walk_y + 1;
      end else begin
        walk_x += 1;
        walk_y -= 1;
        walk_d += 2 * (walk_x - walk_y);
      end
      n++;
      done = (walk_y < 0) || (n >= ResultCap);
      p.last_point = done;
      pending_points.push_back(p);
    end
    if (n > biggest_walk) biggest_walk = n;
  endfunction

  task automatic check_coord(input string name, input coord_t exp_v, input coord_t act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // Offer one circle, after a random gap or back to back, and hold it until the transfer.
  task automatic send_circle(input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
                             input logic [RadW-1:0] r, input logic typed,
                             input point_t typed_pt);
    int gap;
    gap = ((circles_sent % 40) >= 30) ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.center_x <= cx;
    req.center_y <= cy;
    req.radius   <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (typed) pending_points.push_back(typed_pt);
    else walk_circle(cx, cy, r);
    circles_sent++;
    if (r == 0) zero_circles++;
    if (r == RadW'(MaxRadius)) full_circles++;
  endtask

  // Pause the sender until every queued point has come out.
  task automatic drain_points();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && pt.valid && pt.ready) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        $error("unexpected point (%0d, %0d, %0d, %0d) with nothing pending",
               pt.right_x, pt.left_x, pt.lower_y, pt.upper_y);
        err_count++;
      end else begin
        head_pt = pending_points.pop_front();
        check_coord("right_x", head_pt.right_x, pt.right_x);
        check_coord("left_x", head_pt.left_x, pt.left_x);
        check_coord("lower_y", head_pt.lower_y, pt.lower_y);
        check_coord("upper_y", head_pt.upper_y, pt.upper_y);
        if (pt.last_point !== head_pt.last_point) begin
          $error("last_point: expected %0d, got %0d", head_pt.last_point, pt.last_point);
          err_count++;
        end
      end
    end
  end

  // Point receiver: random stalls, quiet stretches, and one long hold-off.
  initial begin
    int gap;
    int rx_count;
    rx_count = 0;
    pt.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && circles_sent >= DirRows + 20) begin
        gap = LongHold;
        long_hold_done = 1'b1;
      end else if ((rx_count % 150) >= 100) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, MaxGap);
      end
      if (gap != 0) begin
        pt.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pt.ready <= 1'b1;
      @(posedge clk);
      while (!pt.valid) @(posedge clk);
      rx_count++;
    end
  end

  initial begin
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [RadW-1:0]   r;
    int                sel;
    rst          <= 1'b1;
    req.valid    <= 1'b0;
    req.center_x <= '0;
    req.center_y <= '0;
    req.radius   <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_circle(dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].r, dir_rows[i].typed,
                  dir_rows[i].pt);
    drain_points();

    for (int i = 0; i < RandCircles; i++) begin
      if (i == RandCircles / 2) drain_points();
      sel = $urandom_range(0, 9);
      if (sel == 0) r = '0;
      else if (sel == 1) r = RadW'(MaxRadius);
      else r = RadW'($urandom_range(0, 31));
      // Lean on the borders so negative and overflowing points show up often.
      if ($urandom_range(0, 7) == 0) cx = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      else cx = CoordW'($urandom_range(0, 1023));
      if ($urandom_range(0, 7) == 0) cy = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      else cy = CoordW'($urandom_range(0, 1023));
      send_circle(cx, cy, r, 1'b0, '0);
    end
    req.valid <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d points from %0d circles (%0d of radius 0, %0d of radius %0d).",
             points_seen, circles_sent, zero_circles, full_circles, MaxRadius);
    $display("Longest walk: %0d points; receiver held off for %0d cycles once.",
             biggest_walk, LongHold);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(WatchdogNs);
    $display("TB_ERROR");
    $finish;
  end

endmodule
